FILE: rtl/core/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("complex_arithmetic_unit: check failed");

// Next-cycle implication, checked out of reset
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("complex_arithmetic_unit: check failed");

`endif

FILE: rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit: command and status codes,
// widths, pipeline latencies, structs, clamp helper and arctangent table.
// No dependencies.
`default_nettype none
package cau_pkg;

	localparam int DATA_W       = 32;
	localparam int WIDE_W       = 66;
	localparam int SQ_W         = 64;
	localparam int TOL_W        = 31;
	localparam int CFG_W        = 63;
	localparam int CFG_IDX_W    = 1;
	localparam int DIV_Q_W      = 33;
	localparam int ROOT_W       = 33;
	localparam int XY_W         = 66;
	localparam int Z_W          = 34;
	localparam int ANGLE_BITS   = 30;
	localparam int CORDIC_STEPS = 31;
	localparam int SQRT_STEPS   = 32;

	// Pipeline latencies, counted from the accepting edge
	localparam int LAT_FRONT  = 2;
	localparam int LAT_DIV    = 2 + DIV_Q_W;
	localparam int LAT_SQRT   = SQRT_STEPS;
	localparam int LAT_CORDIC = 1 + CORDIC_STEPS;
	localparam int LATENCY    = LAT_FRONT + LAT_DIV + 1;
	localparam int EARLY_DLY  = LAT_DIV - 1;
	localparam int ROOT_DLY   = LAT_FRONT + LAT_DIV - (LAT_FRONT + LAT_SQRT);
	localparam int ANGLE_DLY  = LAT_FRONT + LAT_DIV - LAT_CORDIC;

	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_MUL  = 3'd2,
		CMD_DIV  = 3'd3,
		CMD_CONJ = 3'd4,
		CMD_MAG  = 3'd5,
		CMD_ARG  = 3'd6,
		CMD_EQ   = 3'd7
	} cmd_t;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_DIV_REFUSED = 2'd1;
	localparam logic [1:0] ST_SATURATED   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_EQ_TOL  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIV = 1'd1;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     sat;
	} clamp_t;

	// Partial result of the short commands
	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic                     eq;
		logic                     sat;
	} part_t;

	typedef struct packed {
		cmd_t  cmd;
		logic  refuse;
		part_t res;
	} early_t;

	// Front end output at stage 2
	typedef struct packed {
		cmd_t                     cmd;
		logic signed [WIDE_W-1:0] mul_re;
		logic signed [WIDE_W-1:0] mul_im;
		logic signed [WIDE_W-1:0] div_nr;
		logic signed [WIDE_W-1:0] div_ni;
		logic [SQ_W-1:0]          den;
		logic [SQ_W-1:0]          mag_sq;
		part_t                    res;
	} front_t;

	// Sign and magnitude to a saturated 32-bit value
	function automatic clamp_t clamp32(input logic neg, input logic [WIDE_W-1:0] mag);
		clamp_t c;
		c.sat = 1'b0;
		if (!neg) begin
			if (mag > WIDE_W'(32'h7FFF_FFFF)) begin
				c.value = 32'sh7FFF_FFFF;
				c.sat   = 1'b1;
			end else begin
				c.value = mag[DATA_W-1:0];
			end
		end else begin
			if (mag > WIDE_W'(32'h8000_0000)) begin
				c.value = 32'sh8000_0000;
				c.sat   = 1'b1;
			end else begin
				c.value = (~mag[DATA_W-1:0]) + 32'd1;
			end
		end
		return c;
	endfunction

	// atan(2^-i) in Q30
	function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
		logic signed [Z_W-1:0] t;
		case (idx)
			0:  t = 34'sd843314857;
			1:  t = 34'sd497837830;
			2:  t = 34'sd263043837;
			3:  t = 34'sd133525159;
			4:  t = 34'sd67021687;
			5:  t = 34'sd33543516;
			6:  t = 34'sd16775851;
			7:  t = 34'sd8388437;
			8:  t = 34'sd4194283;
			9:  t = 34'sd2097149;
			default: t = (idx < 31) ? (34'sd1 <<< (30 - idx)) : 34'sd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cau_delay.sv
// Enabled shift line used to align results of the pipeline branches.
// Depends on nothing.
`default_nettype none
module cau_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] line_q [DEPTH];

	// shift on every pipeline advance
	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];
endmodule
`default_nettype wire

FILE: rtl/core/cau_front.sv
// Front end: operand products (stage 1), sums and short commands (stage 2).
// Depends on cau_pkg.
`default_nettype none
module cau_front (
	input  logic                              clk,
	input  logic                              en,
	input  logic [2:0]                        command,
	input  logic signed [cau_pkg::DATA_W-1:0] a_real,
	input  logic signed [cau_pkg::DATA_W-1:0] a_imag,
	input  logic signed [cau_pkg::DATA_W-1:0] b_real,
	input  logic signed [cau_pkg::DATA_W-1:0] b_imag,
	input  logic [cau_pkg::TOL_W-1:0]         tol,
	output cau_pkg::front_t                   front
);
	import cau_pkg::*;

	cmd_t                     cmd_s1;
	logic signed [DATA_W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [SQ_W-1:0]   p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [SQ_W-1:0]   sq_ar_s1, sq_ai_s1, sq_br_s1, sq_bi_s1;

	logic signed [DATA_W:0]   s_re, s_im;
	logic [DATA_W:0]          m_re, m_im;
	clamp_t                   c_re, c_im;
	part_t                    part;

	// stage 1: operands and exact products
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= cmd_t'(command);
			ar_s1    <= a_real;
			ai_s1    <= a_imag;
			br_s1    <= b_real;
			bi_s1    <= b_imag;
			p_rr_s1  <= a_real * b_real;
			p_ii_s1  <= a_imag * b_imag;
			p_ri_s1  <= a_real * b_imag;
			p_ir_s1  <= a_imag * b_real;
			sq_ar_s1 <= a_real * a_real;
			sq_ai_s1 <= a_imag * a_imag;
			sq_br_s1 <= b_real * b_real;
			sq_bi_s1 <= b_imag * b_imag;
		end
	end

	// short commands: add, sub, conjugate, equality
	always_comb begin
		unique case (cmd_s1) inside
			CMD_ADD: begin
				s_re = {ar_s1[DATA_W-1], ar_s1} + {br_s1[DATA_W-1], br_s1};
				s_im = {ai_s1[DATA_W-1], ai_s1} + {bi_s1[DATA_W-1], bi_s1};
			end
			CMD_SUB, CMD_EQ: begin
				s_re = {ar_s1[DATA_W-1], ar_s1} - {br_s1[DATA_W-1], br_s1};
				s_im = {ai_s1[DATA_W-1], ai_s1} - {bi_s1[DATA_W-1], bi_s1};
			end
			default: begin
				s_re = {ar_s1[DATA_W-1], ar_s1};
				s_im = -{ai_s1[DATA_W-1], ai_s1};
			end
		endcase
		m_re = s_re[DATA_W] ? (DATA_W+1)'(-s_re) : (DATA_W+1)'(s_re);
		m_im = s_im[DATA_W] ? (DATA_W+1)'(-s_im) : (DATA_W+1)'(s_im);
		c_re = clamp32(s_re[DATA_W], WIDE_W'(m_re));
		c_im = clamp32(s_im[DATA_W], WIDE_W'(m_im));
		if (cmd_s1 == CMD_EQ) begin
			part.re  = '0;
			part.im  = '0;
			part.sat = 1'b0;
			part.eq  = (m_re < (DATA_W+1)'(tol)) && (m_im < (DATA_W+1)'(tol));
		end else begin
			part.re  = c_re.value;
			part.im  = c_im.value;
			part.sat = c_re.sat | c_im.sat;
			part.eq  = 1'b0;
		end
	end

	// stage 2: sums of products
	always_ff @(posedge clk) begin
		if (en) begin
			front.cmd    <= cmd_s1;
			front.mul_re <= WIDE_W'(p_rr_s1) - WIDE_W'(p_ii_s1);
			front.mul_im <= WIDE_W'(p_ri_s1) + WIDE_W'(p_ir_s1);
			front.div_nr <= WIDE_W'(p_rr_s1) + WIDE_W'(p_ii_s1);
			front.div_ni <= WIDE_W'(p_ir_s1) - WIDE_W'(p_ri_s1);
			front.den    <= $unsigned(sq_br_s1) + $unsigned(sq_bi_s1);
			front.mag_sq <= $unsigned(sq_ar_s1) + $unsigned(sq_ai_s1);
			front.res    <= part;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/cau_div_lane.sv
// One pipelined restoring divider lane: |num| * 2^FRAC_BITS / den,
// one quotient bit per stage, with an overflow flag. Depends on cau_pkg.
`default_nettype none
module cau_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [cau_pkg::WIDE_W-1:0] num,
	input  logic [cau_pkg::SQ_W-1:0]          den,
	output logic [cau_pkg::DIV_Q_W-1:0]       quo,
	output logic                              neg,
	output logic                              ovf
);
	import cau_pkg::*;

	localparam int RW        = SQ_W + DIV_Q_W;
	localparam int STEPS     = DIV_Q_W;
	localparam int OVF_SHIFT = DIV_Q_W - FRAC_BITS;

	logic [SQ_W-1:0]    mag_s1, den_s1;
	logic               neg_s1;
	logic [RW-1:0]      rem_s [0:STEPS-1];
	logic [SQ_W-1:0]    dvs_s [0:STEPS-1];
	logic [DIV_Q_W-1:0] quo_s [1:STEPS];
	logic               neg_s [0:STEPS];
	logic               ovf_s [0:STEPS];

	// split sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[WIDE_W-1];
			mag_s1 <= num[WIDE_W-1] ? SQ_W'(-num) : SQ_W'(num);
			den_s1 <= den;
		end
	end

	// scaled dividend and overflow check (quotient of 2^33 or more)
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(mag_s1) << FRAC_BITS;
			dvs_s[0] <= den_s1;
			neg_s[0] <= neg_s1;
			ovf_s[0] <= RW'(mag_s1) >= (RW'(den_s1) << OVF_SHIFT);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = STEPS - 1 - j;
		logic [RW-1:0]      sub_den;
		logic               take;
		logic [DIV_Q_W-1:0] quo_in;

		assign sub_den = RW'(dvs_s[j]) << K;
		assign take    = rem_s[j] >= sub_den;

		if (j == 0) begin : g_first
			assign quo_in = '0;
		end else begin : g_next
			assign quo_in = quo_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j+1] <= {quo_in[DIV_Q_W-2:0], take};
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end

		if (j < STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= take ? (rem_s[j] - sub_den) : rem_s[j];
					dvs_s[j+1] <= dvs_s[j];
				end
			end
		end
	end

	assign quo = quo_s[STEPS];
	assign neg = neg_s[STEPS];
	assign ovf = ovf_s[STEPS];
endmodule
`default_nettype wire

FILE: rtl/core/cau_sqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per
// stage. Depends on cau_pkg.
`default_nettype none
module cau_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [cau_pkg::SQ_W-1:0]    n,
	output logic [cau_pkg::ROOT_W-1:0]  root
);
	import cau_pkg::*;

	logic [SQ_W-1:0] n_s   [1:SQRT_STEPS-1];
	logic [SQ_W-1:0] res_s [1:SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
		logic [SQ_W-1:0] n_in, r_in, trial;
		logic            take;

		if (j == 0) begin : g_first
			assign n_in = n;
			assign r_in = '0;
		end else begin : g_next
			assign n_in = n_s[j];
			assign r_in = res_s[j];
		end

		assign trial = r_in + BIT;
		assign take  = n_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				res_s[j+1] <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
			end
		end

		if (j < SQRT_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					n_s[j+1] <= take ? (n_in - trial) : n_in;
				end
			end
		end
	end

	assign root = res_s[SQRT_STEPS][ROOT_W-1:0];
endmodule
`default_nettype wire

FILE: rtl/core/cau_cordic.sv
// Pipelined CORDIC vectoring for the argument of a: quadrant pre-rotation
// stage then one micro-rotation per stage, angle in Q30. Depends on cau_pkg.
`default_nettype none
module cau_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [cau_pkg::DATA_W-1:0] a_real,
	input  logic signed [cau_pkg::DATA_W-1:0] a_imag,
	output logic signed [cau_pkg::Z_W-1:0]    angle
);
	import cau_pkg::*;

	localparam int EXT = XY_W - DATA_W - ANGLE_BITS;

	logic signed [XY_W-1:0] xa, ya, x0, y0;
	logic signed [Z_W-1:0]  z0;
	logic signed [XY_W-1:0] x_s    [0:CORDIC_STEPS-1];
	logic signed [XY_W-1:0] y_s    [0:CORDIC_STEPS-1];
	logic signed [Z_W-1:0]  z_s    [0:CORDIC_STEPS];
	logic                   zero_s [0:CORDIC_STEPS];

	// scale to Q30 and fold the left half-plane
	always_comb begin
		xa = {{EXT{a_real[DATA_W-1]}}, a_real, {ANGLE_BITS{1'b0}}};
		ya = {{EXT{a_imag[DATA_W-1]}}, a_imag, {ANGLE_BITS{1'b0}}};
		if (a_real[DATA_W-1]) begin
			if (!a_imag[DATA_W-1]) begin
				x0 = ya;
				y0 = -xa;
				z0 = HALF_PI_Q30;
			end else begin
				x0 = -ya;
				y0 = xa;
				z0 = -HALF_PI_Q30;
			end
		end else begin
			x0 = xa;
			y0 = ya;
			z0 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x0;
			y_s[0]    <= y0;
			z_s[0]    <= z0;
			zero_s[0] <= (a_real == '0) && (a_imag == '0);
		end
	end

	// micro-rotations
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [Z_W-1:0] T_I = atan_q30(i);
		logic ypos;

		assign ypos = !y_s[i][XY_W-1] && (y_s[i] != '0);

		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1]    <= ypos ? (z_s[i] + T_I) : (z_s[i] - T_I);
				zero_s[i+1] <= zero_s[i];
			end
		end

		if (i < CORDIC_STEPS - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i+1] <= ypos ? (x_s[i] + (y_s[i] >>> i)) : (x_s[i] - (y_s[i] >>> i));
					y_s[i+1] <= ypos ? (y_s[i] - (x_s[i] >>> i)) : (y_s[i] + (x_s[i] >>> i));
				end
			end
		end
	end

	// the origin has angle zero
	assign angle = zero_s[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];
endmodule
`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Throughput is one transaction per cycle while the output is not held.
// The longest branch is the 35-stage divider lanes.
// The whole pipeline holds while a result waits at the output.
// Reset clears all valid bits and sets both configuration registers to 1.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        command,
	input  logic signed [cau_pkg::DATA_W-1:0] a_real,
	input  logic signed [cau_pkg::DATA_W-1:0] a_imag,
	input  logic signed [cau_pkg::DATA_W-1:0] b_real,
	input  logic signed [cau_pkg::DATA_W-1:0] b_imag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [cau_pkg::DATA_W-1:0] result_real,
	output logic signed [cau_pkg::DATA_W-1:0] result_imag,
	output logic                              is_equal,
	output logic [1:0]                        status,
	input  logic                              cfg_wr_en,
	input  logic [cau_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cau_pkg::CFG_W-1:0]         cfg_data
);
	import cau_pkg::*;

	`include "complex_arithmetic_unit_assert.svh"

	logic [TOL_W-1:0]       equal_tolerance_q;
	logic [CFG_W-1:0]       min_divisor_power_q;
	logic [LATENCY-1:0]     vld_q;
	logic                   adv;

	front_t                 fr;
	logic [WIDE_W-1:0]      mm_re, mm_im;
	clamp_t                 cm_re, cm_im;
	early_t                 early_nx, early_s3, early_d;

	logic [DIV_Q_W-1:0]     q_re, q_im;
	logic                   qneg_re, qneg_im, qovf_re, qovf_im;
	logic [ROOT_W-1:0]      root, root_d;
	logic signed [Z_W-1:0]  angle, angle_d;
	logic [Z_W-1:0]         zmag;

	clamp_t                 f_re, f_im;
	logic signed [DATA_W-1:0] fin_re, fin_im;
	logic                   fin_sat;
	logic [1:0]             fin_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			equal_tolerance_q   <= TOL_W'(1);
			min_divisor_power_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_EQ_TOL:  equal_tolerance_q   <= cfg_data[TOL_W-1:0];
				REG_MIN_DIV: min_divisor_power_q <= cfg_data;
			endcase
		end
	end

	// global advance: the pipeline moves unless the output is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LATENCY-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[LATENCY-1];

	cau_front u_front (
		.clk     (clk),
		.en      (adv),
		.command (command),
		.a_real  (a_real),
		.a_imag  (a_imag),
		.b_real  (b_real),
		.b_imag  (b_imag),
		.tol     (equal_tolerance_q),
		.front   (fr)
	);

	// stage 3: product scaling, division refusal check
	always_comb begin
		mm_re = fr.mul_re[WIDE_W-1] ? WIDE_W'(-fr.mul_re) : WIDE_W'(fr.mul_re);
		mm_im = fr.mul_im[WIDE_W-1] ? WIDE_W'(-fr.mul_im) : WIDE_W'(fr.mul_im);
		cm_re = clamp32(fr.mul_re[WIDE_W-1], mm_re >> FRAC_BITS);
		cm_im = clamp32(fr.mul_im[WIDE_W-1], mm_im >> FRAC_BITS);
		early_nx.cmd    = fr.cmd;
		early_nx.refuse = (fr.cmd == CMD_DIV) &&
			((fr.den == '0) || (fr.den < SQ_W'(min_divisor_power_q)));
		if (fr.cmd == CMD_MUL) begin
			early_nx.res.re  = cm_re.value;
			early_nx.res.im  = cm_im.value;
			early_nx.res.eq  = 1'b0;
			early_nx.res.sat = cm_re.sat | cm_im.sat;
		end else begin
			early_nx.res = fr.res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			early_s3 <= early_nx;
		end
	end

	cau_delay #(.WIDTH($bits(early_t)), .DEPTH(EARLY_DLY)) u_early_dly (
		.clk (clk),
		.en  (adv),
		.d   (early_s3),
		.q   (early_d)
	);

	cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk (clk),
		.en  (adv),
		.num (fr.div_nr),
		.den (fr.den),
		.quo (q_re),
		.neg (qneg_re),
		.ovf (qovf_re)
	);

	cau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk (clk),
		.en  (adv),
		.num (fr.div_ni),
		.den (fr.den),
		.quo (q_im),
		.neg (qneg_im),
		.ovf (qovf_im)
	);

	cau_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.n    (fr.mag_sq),
		.root (root)
	);

	cau_delay #(.WIDTH(ROOT_W), .DEPTH(ROOT_DLY)) u_root_dly (
		.clk (clk),
		.en  (adv),
		.d   (root),
		.q   (root_d)
	);

	cau_cordic u_cordic (
		.clk    (clk),
		.en     (adv),
		.a_real (a_real),
		.a_imag (a_imag),
		.angle  (angle)
	);

	cau_delay #(.WIDTH(Z_W), .DEPTH(ANGLE_DLY)) u_angle_dly (
		.clk (clk),
		.en  (adv),
		.d   (angle),
		.q   (angle_d)
	);

	// final selection and saturation
	always_comb begin
		zmag    = angle_d[Z_W-1] ? Z_W'(-angle_d) : Z_W'(angle_d);
		f_re    = clamp32(1'b0, '0);
		f_im    = clamp32(1'b0, '0);
		fin_re  = early_d.res.re;
		fin_im  = early_d.res.im;
		fin_sat = early_d.res.sat;
		unique case (early_d.cmd) inside
			CMD_DIV: begin
				if (early_d.refuse) begin
					fin_re  = '0;
					fin_im  = '0;
					fin_sat = 1'b0;
				end else begin
					f_re    = clamp32(qneg_re, qovf_re ? '1 : WIDE_W'(q_re));
					f_im    = clamp32(qneg_im, qovf_im ? '1 : WIDE_W'(q_im));
					fin_re  = f_re.value;
					fin_im  = f_im.value;
					fin_sat = f_re.sat | f_im.sat;
				end
			end
			CMD_MAG: begin
				f_re    = clamp32(1'b0, WIDE_W'(root_d));
				fin_re  = f_re.value;
				fin_im  = '0;
				fin_sat = f_re.sat;
			end
			CMD_ARG: begin
				f_re    = clamp32(angle_d[Z_W-1], WIDE_W'(zmag >> (ANGLE_BITS - FRAC_BITS)));
				fin_re  = f_re.value;
				fin_im  = '0;
				fin_sat = f_re.sat;
			end
			default: begin
				fin_re  = early_d.res.re;
				fin_im  = early_d.res.im;
				fin_sat = early_d.res.sat;
			end
		endcase
		if (early_d.refuse) begin
			fin_status = ST_DIV_REFUSED;
		end else if (fin_sat) begin
			fin_status = ST_SATURATED;
		end else begin
			fin_status = ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			result_real <= fin_re;
			result_imag <= fin_im;
			is_equal    <= early_d.res.eq;
			status      <= fin_status;
		end
	end

	// checks
	`CAU_ASSERT_NOW(a_refused_zero, out_valid && (status == ST_DIV_REFUSED), (result_real == '0) && (result_imag == '0))
	`CAU_ASSERT_NOW(a_equal_clean, out_valid && is_equal, (status == ST_OK) && (result_real == '0) && (result_imag == '0))
	`CAU_ASSERT_NOW(a_sat_extreme, out_valid && (status == ST_SATURATED), (result_real == 32'sh7FFF_FFFF) || (result_real == 32'sh8000_0000) || (result_imag == 32'sh7FFF_FFFF) || (result_imag == 32'sh8000_0000))
	`CAU_ASSERT_NEXT(a_stall_keeps_valid, out_valid && !out_ready, out_valid && $stable({result_real, result_imag, is_equal, status}))

endmodule
`default_nettype wire
